[hw/rtl/prpd_pkg.sv]
// Shared constants, codes and types for the PCX run-length planar pixel decoder.
// No dependencies; used by prpd_ram, prpd_ctrl, prpd_dp and the core top level.
package prpd_pkg;

    localparam int MAX_ROW_BYTES = 1024;
    localparam int MAX_PLANES    = 4;

    // Configuration register indexes
    localparam logic [2:0] CFG_RLE_ENABLE     = 3'd0;
    localparam logic [2:0] CFG_BITS_PER_PLANE = 3'd1;
    localparam logic [2:0] CFG_PLANE_COUNT    = 3'd2;
    localparam logic [2:0] CFG_ROW_BYTES      = 3'd3;
    localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_IMAGE_HEIGHT   = 3'd5;

    // Register reset values
    localparam logic        RST_RLE_ENABLE     = 1'b1;
    localparam logic [3:0]  RST_BITS_PER_PLANE = 4'd1;
    localparam logic [2:0]  RST_PLANE_COUNT    = 3'd1;
    localparam logic [10:0] RST_ROW_BYTES      = 11'd80;
    localparam logic [16:0] RST_IMAGE_WIDTH    = 17'd640;
    localparam logic [16:0] RST_IMAGE_HEIGHT   = 17'd480;

    // Run marker: both top bits set, low six bits give the count
    localparam logic [7:0] RUN_MARK = 8'hC0;

    // Mode codes: plane count in bits 10..8, bits per plane in bits 3..0
    localparam logic [10:0] MODE_1BIT_1P = 11'h101;
    localparam logic [10:0] MODE_2BIT_1P = 11'h102;
    localparam logic [10:0] MODE_8BIT_1P = 11'h108;
    localparam logic [10:0] MODE_1BIT_3P = 11'h301;
    localparam logic [10:0] MODE_1BIT_4P = 11'h401;
    localparam logic [10:0] MODE_RGB     = 11'h308;

    localparam logic [16:0] MAX_HEIGHT = 17'h10000;

    function automatic logic [10:0] mode_code(input logic [3:0] bits, input logic [2:0] planes);
        mode_code = {planes, 4'h0, bits};
    endfunction

    typedef struct packed {
        logic load_byte;
        logic step;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rle_en;
        logic complete;
        logic step_ok;
        logic flush_ok;
        logic step_completes;
    } dp_status_t;

    typedef struct packed {
        logic [31:0] data;
        logic [3:0]  count;
        logic [15:0] row;
        logic [15:0] col;
        logic        done;
        logic        err;
    } result_t;

endpackage

[hw/rtl/pcx_rle_planar_pixel_decoder_core.sv]
// Top level of the PCX run-length planar pixel decoder.
// Depends on prpd_pkg, prpd_ctrl, prpd_dp (which holds the prpd_ram line store).
//
//  channel   | signals                                   | dir | beat
//  ----------+-------------------------------------------+-----+---------------------------
//  input     | in_valid/in_ready, body_byte              | in  | one body byte
//  result    | out_valid/out_ready, pixel_data .. error  | out | one pixel group or marker
//  config    | cfg_valid/cfg_ready, cfg_index, cfg_data  | in  | one register write
//
// A run marker or a zero-length run is taken in the idle state alone. Every decoded byte of a run
// passes a line store read state, then a convert and advance state; a byte with a
// repeat count is accepted in idle, passes both states for each repeat up to the frame end,
// and the run closes in a flush state; the last result of a byte leaves through the output register.
// A stalled result stops the step loop.
// Reset clears control state only; the line store holds no valid data until written.
module pcx_rle_planar_pixel_decoder_core #(
    parameter int MAX_ROW_BYTES = prpd_pkg::MAX_ROW_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  body_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_data,
    output logic [3:0]  pixel_count,
    output logic [15:0] row_index,
    output logic [15:0] first_column,
    output logic        last_in_run,
    output logic        frame_done,
    output logic        mode_error
);

    prpd_pkg::ctrl_cmd_t  cmd;
    prpd_pkg::dp_status_t st;
    prpd_pkg::result_t    res;
    logic                 cfg_we;
    logic                 cfg_rearm;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_rearm = cfg_we && (cfg_index <= prpd_pkg::CFG_IMAGE_HEIGHT);

    prpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_rearm (cfg_rearm),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .body_byte (body_byte),
        .st        (st),
        .cmd       (cmd)
    );

    prpd_dp #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .body_byte (body_byte),
        .cmd       (cmd),
        .st        (st),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (res),
        .out_last  (last_in_run)
    );

    assign pixel_data   = res.data;
    assign pixel_count  = res.count;
    assign row_index    = res.row;
    assign first_column = res.col;
    assign frame_done   = res.done;
    assign mode_error   = res.err;

endmodule

[hw/rtl/prpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on prpd_pkg for its default depth; instanced once per stored plane by prpd_dp.
module prpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = prpd_pkg::MAX_ROW_BYTES
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/prpd_ctrl.sv]
// Sequencer for the decoder: run-length state, repeat counting and step/flush commands.
// Depends on prpd_pkg; drives prpd_dp through ctrl_cmd_t and reads dp_status_t.
module prpd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_rearm,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             body_byte,
    input  prpd_pkg::dp_status_t   st,
    output prpd_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CONV,
        ST_FLUSH
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] run_len_reg, run_len_next;
    logic       await_reg, await_next;
    logic [5:0] iter_reg, iter_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        run_len_next = run_len_reg;
        await_next   = await_reg;
        iter_next    = iter_reg;
        cmd          = '0;
        if (cfg_rearm)
        begin
            run_len_next = '0;
            await_next   = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    // drop everything once the last row is finished
                    if (accept && !st.complete)
                    begin
                        if (st.rle_en && await_reg)
                        begin
                            await_next   = 1'b0;
                            run_len_next = '0;
                            if (run_len_reg != '0)
                            begin
                                iter_next     = run_len_reg;
                                cmd.load_byte = 1'b1;
                                state_next    = ST_READ;
                            end
                        end
                        else if (st.rle_en && ((body_byte & prpd_pkg::RUN_MARK) == prpd_pkg::RUN_MARK))
                        begin
                            run_len_next = body_byte[5:0];
                            await_next   = 1'b1;
                        end
                        else
                        begin
                            iter_next     = 6'd1;
                            cmd.load_byte = 1'b1;
                            state_next    = ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_next = ST_CONV;
                end
                ST_CONV:
                begin
                    if (st.step_ok)
                    begin
                        cmd.step  = 1'b1;
                        iter_next = iter_reg - 6'd1;
                        if (iter_reg == 6'd1 || st.step_completes)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (st.flush_ok)
                    begin
                        cmd.flush  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            run_len_reg <= '0;
            await_reg   <= 1'b0;
            iter_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            run_len_reg <= run_len_next;
            await_reg   <= await_next;
            iter_reg    <= iter_next;
        end
    end

endmodule

[hw/rtl/prpd_dp.sv]
// Datapath: configuration registers, row/plane position, plane line store,
// pixel packing, held result and output register. Depends on prpd_pkg and prpd_ram.
module prpd_dp #(
    parameter int MAX_ROW_BYTES = prpd_pkg::MAX_ROW_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [16:0]            cfg_data,
    input  logic [7:0]             body_byte,
    input  prpd_pkg::ctrl_cmd_t    cmd,
    output prpd_pkg::dp_status_t   st,
    input  logic                   out_ready,
    output logic                   out_valid,
    output prpd_pkg::result_t      out_res,
    output logic                   out_last
);

    localparam int BPW    = $clog2(MAX_ROW_BYTES);
    localparam int NSTORE = prpd_pkg::MAX_PLANES - 1;

    logic        rle_en_reg;
    logic [3:0]  bpp_reg;
    logic [2:0]  pcount_reg;
    logic [10:0] row_bytes_reg;
    logic [16:0] width_reg;
    logic [16:0] height_reg;

    logic [7:0]     byte_reg;
    logic [BPW-1:0] bp_reg;
    logic [1:0]     pp_reg;
    logic [15:0]    row_reg;
    logic           complete_reg;

    prpd_pkg::result_t hold_reg;
    logic              hold_valid_reg;
    prpd_pkg::result_t out_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic           rearm;
    logic [2:0]     eff_planes;
    logic [31:0]    eff_rows;
    logic [16:0]    eff_height;
    logic [10:0]    mode;
    logic           supported;
    logic           store_case;
    logic [BPW:0]   bp_inc;
    logic           row_end;
    logic           line_end;
    logic           last_row;
    logic [7:0]     rd [NSTORE];
    logic [7:0]     plane_byte [prpd_pkg::MAX_PLANES];
    logic [31:0]    pix_data;
    logic [3:0]     pix_n;
    logic [BPW+2:0] col_base;
    logic [31:0]    col32;
    logic [31:0]    left;
    logic           group;
    logic           produce;
    logic           load_out;
    prpd_pkg::result_t new_res;

    assign rearm = cfg_we && (cfg_index <= prpd_pkg::CFG_IMAGE_HEIGHT);

    // Clamp plane count, row bytes and height to their usable ranges
    always_comb
    begin
        if (pcount_reg == 3'd0)
        begin
            eff_planes = 3'd1;
        end
        else if (pcount_reg > 3'(prpd_pkg::MAX_PLANES))
        begin
            eff_planes = 3'(prpd_pkg::MAX_PLANES);
        end
        else
        begin
            eff_planes = pcount_reg;
        end

        if (row_bytes_reg == 11'd0)
        begin
            eff_rows = 32'd1;
        end
        else if (32'(row_bytes_reg) > 32'(MAX_ROW_BYTES))
        begin
            eff_rows = 32'(MAX_ROW_BYTES);
        end
        else
        begin
            eff_rows = 32'(row_bytes_reg);
        end

        if (height_reg == 17'd0)
        begin
            eff_height = 17'd1;
        end
        else if (height_reg > prpd_pkg::MAX_HEIGHT)
        begin
            eff_height = prpd_pkg::MAX_HEIGHT;
        end
        else
        begin
            eff_height = height_reg;
        end
    end

    assign mode      = prpd_pkg::mode_code(bpp_reg, pcount_reg);
    assign supported = (mode == prpd_pkg::MODE_1BIT_1P) || (mode == prpd_pkg::MODE_2BIT_1P) ||
                       (mode == prpd_pkg::MODE_8BIT_1P) || (mode == prpd_pkg::MODE_1BIT_3P) ||
                       (mode == prpd_pkg::MODE_1BIT_4P) || (mode == prpd_pkg::MODE_RGB);

    assign store_case = ({1'b0, pp_reg} + 3'd1) < eff_planes;
    assign bp_inc     = {1'b0, bp_reg} + {{BPW{1'b0}}, 1'b1};
    assign row_end    = 32'(bp_inc) >= eff_rows;
    assign line_end   = row_end && !store_case;
    assign last_row   = ({1'b0, row_reg} + 17'd1) >= eff_height;

    // Line store: one RAM per earlier plane, all read at the current byte position
    for (genvar q = 0; q < NSTORE; q++)
    begin : g_store
        prpd_ram #(
            .WIDTH (8),
            .DEPTH (MAX_ROW_BYTES)
        ) u_ram (
            .clk   (clk),
            .we    (cmd.step && store_case && (pp_reg == 2'(q))),
            .waddr (bp_reg),
            .wdata (byte_reg),
            .raddr (bp_reg),
            .rdata (rd[q])
        );
    end

    // Bytes of each plane for the planar modes; last plane is the live byte
    always_comb
    begin
        for (int q = 0; q < prpd_pkg::MAX_PLANES; q++)
        begin
            if (3'(q + 1) == eff_planes)
            begin
                plane_byte[q] = byte_reg;
            end
            else if (q < NSTORE && 3'(q + 1) < eff_planes)
            begin
                plane_byte[q] = rd[(q < NSTORE) ? q : 0];
            end
            else
            begin
                plane_byte[q] = 8'h00;
            end
        end
    end

    always_comb
    begin
        pix_data = '0;
        pix_n    = '0;
        col_base = '0;
        unique case (mode)
            prpd_pkg::MODE_2BIT_1P:
            begin
                pix_n    = 4'd4;
                col_base = {1'b0, bp_reg, 2'b00};
                for (int j = 0; j < 4; j++)
                begin
                    pix_data[4*j +: 4] = {2'b00, byte_reg[6-2*j +: 2]};
                end
            end
            prpd_pkg::MODE_8BIT_1P:
            begin
                pix_n    = 4'd1;
                col_base = {3'b000, bp_reg};
                pix_data = {24'h0, byte_reg};
            end
            prpd_pkg::MODE_RGB:
            begin
                pix_n    = 4'd1;
                col_base = {3'b000, bp_reg};
                pix_data = {8'h00, rd[0], rd[1], byte_reg};
            end
            default:
            begin
                pix_n    = 4'd8;
                col_base = {bp_reg, 3'b000};
                for (int j = 0; j < 8; j++)
                begin
                    for (int q = 0; q < prpd_pkg::MAX_PLANES; q++)
                    begin
                        pix_data[4*j + q] = plane_byte[q][7-j];
                    end
                end
            end
        endcase
    end

    assign col32 = 32'(col_base);
    assign left  = 32'(width_reg) - col32;
    assign group = !store_case && supported && (col32 < 32'(width_reg));

    always_comb
    begin
        new_res = '0;
        new_res.row = row_reg;
        if (group)
        begin
            new_res.data  = pix_data;
            new_res.count = (left < 32'(pix_n)) ? left[3:0] : pix_n;
            new_res.col   = 16'(col_base);
            new_res.done  = line_end && last_row;
        end
        else
        begin
            // row end marker: error in unsupported modes, frame end otherwise
            new_res.done = last_row;
            new_res.err  = !supported;
        end
    end

    assign produce  = group || (line_end && (!supported || last_row));
    assign load_out = (cmd.step && produce && hold_valid_reg) || (cmd.flush && hold_valid_reg);

    assign st.rle_en         = rle_en_reg;
    assign st.complete       = complete_reg;
    assign st.step_ok        = !(hold_valid_reg && out_valid_reg && !out_ready);
    assign st.flush_ok       = !hold_valid_reg || !out_valid_reg || out_ready;
    assign st.step_completes = line_end && last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_en_reg     <= prpd_pkg::RST_RLE_ENABLE;
            bpp_reg        <= prpd_pkg::RST_BITS_PER_PLANE;
            pcount_reg     <= prpd_pkg::RST_PLANE_COUNT;
            row_bytes_reg  <= prpd_pkg::RST_ROW_BYTES;
            width_reg      <= prpd_pkg::RST_IMAGE_WIDTH;
            height_reg     <= prpd_pkg::RST_IMAGE_HEIGHT;
            bp_reg         <= '0;
            pp_reg         <= '0;
            row_reg        <= '0;
            complete_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    prpd_pkg::CFG_RLE_ENABLE:     rle_en_reg    <= cfg_data[0];
                    prpd_pkg::CFG_BITS_PER_PLANE: bpp_reg       <= cfg_data[3:0];
                    prpd_pkg::CFG_PLANE_COUNT:    pcount_reg    <= cfg_data[2:0];
                    prpd_pkg::CFG_ROW_BYTES:      row_bytes_reg <= cfg_data[10:0];
                    prpd_pkg::CFG_IMAGE_WIDTH:    width_reg     <= cfg_data;
                    prpd_pkg::CFG_IMAGE_HEIGHT:   height_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (rearm)
            begin
                bp_reg       <= '0;
                pp_reg       <= '0;
                row_reg      <= '0;
                complete_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                // advance byte, then plane, then row
                if (row_end)
                begin
                    bp_reg <= '0;
                    pp_reg <= store_case ? (pp_reg + 2'd1) : 2'd0;
                    if (line_end)
                    begin
                        if (last_row)
                        begin
                            complete_reg <= 1'b1;
                        end
                        else
                        begin
                            row_reg <= row_reg + 16'd1;
                        end
                    end
                end
                else
                begin
                    bp_reg <= bp_inc[BPW-1:0];
                end
            end

            if (cmd.step && produce)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= body_byte;
        end
        if (cmd.step && produce)
        begin
            hold_reg <= new_res;
        end
        if (load_out)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

endmodule

[tb/pcx_decode_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the PCX run-length planar pixel decoder: follows register writes and body
// beats, predicts the pixel groups each beat causes and compares every result beat.
// Depends on prpd_pkg for register indexes, reset values, the run marker and mode codes.
module pcx_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  body_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] pixel_data,
    input  logic [3:0]  pixel_count,
    input  logic [15:0] row_index,
    input  logic [15:0] first_column,
    input  logic        last_in_run,
    input  logic        frame_done,
    input  logic        mode_error,
    output int          mismatches,
    output int          groups_due,
    output logic        image_done
);

    typedef struct packed {
        logic [31:0] data;
        logic [3:0]  count;
        logic [15:0] row;
        logic [15:0] col;
        logic        last;
        logic        done;
        logic        err;
    } pix_group_t;

    // register copies
    logic        rle_on;
    logic [3:0]  plane_bits;
    logic [2:0]  plane_cfg;
    logic [10:0] row_bytes_cfg;
    logic [16:0] width_cfg;
    logic [16:0] height_cfg;

    // decoder state
    logic [7:0]  line_mem [0:(prpd_pkg::MAX_PLANES-1)*prpd_pkg::MAX_ROW_BYTES-1];
    int          run_len;
    bit          run_armed;
    int          byte_col;
    int          plane_at;
    int          row_at;
    bit          frame_over;

    pix_group_t  due_q [$];
    pix_group_t  held;
    bit          held_valid;
    pix_group_t  seen;
    pix_group_t  want;
    int          fails;

    function automatic string show_group(input pix_group_t g);
        return $sformatf("data %h count %0d row %0d col %0d last %b done %b err %b",
                         g.data, g.count, g.row, g.col, g.last, g.done, g.err);
    endfunction

    task automatic report_mismatch(input string msg);
        if (fails < 100)
            $display("%0t ns: %s", $time, msg);
        fails++;
    endtask

    task automatic rearm_decoder();
        run_len    = 0;
        run_armed  = 0;
        byte_col   = 0;
        plane_at   = 0;
        row_at     = 0;
        frame_over = 0;
    endtask

    // Hold the newest group back so the last one of a beat can be marked.
    task automatic stage_group(input logic [31:0] data, input int cnt, input int row,
                               input int col, input bit done, input bit err);
        if (held_valid)
            due_q.push_back(held);
        held.data  = data;
        held.count = 4'(cnt);
        held.row   = 16'(row);
        held.col   = 16'(col);
        held.last  = 1'b0;
        held.done  = done;
        held.err   = err;
        held_valid = 1;
    endtask

    task automatic place_byte(input logic [7:0] b);
        int          np;
        int          row_len;
        int          hgt;
        int          n;
        int          col;
        int          q;
        int          j;
        logic [10:0] mode;
        bit          ok;
        bit          added;
        bit          last_row;
        logic [31:0] data;
        logic [7:0]  pl [0:3];
        np = (plane_cfg == 3'd0) ? 1 :
             (int'(plane_cfg) > prpd_pkg::MAX_PLANES) ? prpd_pkg::MAX_PLANES :
             int'(plane_cfg);
        row_len = (row_bytes_cfg == 11'd0) ? 1 :
                  (int'(row_bytes_cfg) > prpd_pkg::MAX_ROW_BYTES) ? prpd_pkg::MAX_ROW_BYTES :
                  int'(row_bytes_cfg);
        hgt = (height_cfg == 17'd0) ? 1 :
              (height_cfg > prpd_pkg::MAX_HEIGHT) ? int'(prpd_pkg::MAX_HEIGHT) :
              int'(height_cfg);
        mode = {plane_cfg, 4'h0, plane_bits};
        ok = (mode == prpd_pkg::MODE_1BIT_1P) || (mode == prpd_pkg::MODE_2BIT_1P) ||
             (mode == prpd_pkg::MODE_8BIT_1P) || (mode == prpd_pkg::MODE_1BIT_3P) ||
             (mode == prpd_pkg::MODE_1BIT_4P) || (mode == prpd_pkg::MODE_RGB);
        added = 0;
        data  = 32'h0;
        n     = 0;
        col   = 0;

        if (plane_at + 1 < np) begin
            line_mem[plane_at * prpd_pkg::MAX_ROW_BYTES + byte_col] = b;
        end
        else if (ok) begin
            case (mode)
                prpd_pkg::MODE_2BIT_1P:
                begin
                    n   = 4;
                    col = byte_col * 4;
                    for (j = 0; j < 4; j++)
                        data[4*j +: 2] = b[6-2*j +: 2];
                end
                prpd_pkg::MODE_8BIT_1P:
                begin
                    n    = 1;
                    col  = byte_col;
                    data = {24'h0, b};
                end
                prpd_pkg::MODE_RGB:
                begin
                    n    = 1;
                    col  = byte_col;
                    data = {8'h0, line_mem[byte_col],
                            line_mem[prpd_pkg::MAX_ROW_BYTES + byte_col], b};
                end
                default:
                begin
                    // one bit per plane: plane q gives bit q of each nibble
                    for (q = 0; q < 4; q++)
                        pl[q] = 8'h00;
                    for (q = 0; q + 1 < np; q++)
                        pl[q] = line_mem[q * prpd_pkg::MAX_ROW_BYTES + byte_col];
                    pl[np-1] = b;
                    n   = 8;
                    col = byte_col * 8;
                    for (j = 0; j < 8; j++)
                        for (q = 0; q < np; q++)
                            data[4*j + q] = pl[q][7-j];
                end
            endcase
            if (col < int'(width_cfg)) begin
                if (int'(width_cfg) - col < n)
                    n = int'(width_cfg) - col;
                stage_group(data, n, row_at, col, 1'b0, 1'b0);
                added = 1;
            end
        end

        byte_col++;
        if (byte_col >= row_len) begin
            byte_col = 0;
            plane_at++;
            if (plane_at >= np) begin
                last_row = (row_at + 1 >= hgt);
                plane_at = 0;
                if (!ok)
                    stage_group(32'h0, 0, row_at, 0, last_row, 1'b1);
                else if (last_row) begin
                    if (added)
                        held.done = 1'b1;
                    else
                        stage_group(32'h0, 0, row_at, 0, 1'b1, 1'b0);
                end
                if (last_row)
                    frame_over = 1;
                else
                    row_at++;
            end
        end
    endtask

    task automatic decode_body_beat(input logic [7:0] b);
        int reps;
        int i;
        bit marker;
        reps   = 1;
        marker = 0;
        if (!frame_over) begin
            if (rle_on) begin
                if (run_armed) begin
                    reps      = run_len;
                    run_len   = 0;
                    run_armed = 0;
                end
                else if ((b & prpd_pkg::RUN_MARK) == prpd_pkg::RUN_MARK) begin
                    run_len   = int'(b[5:0]);
                    run_armed = 1;
                    marker    = 1;
                end
            end
            if (!marker) begin
                held_valid = 0;
                for (i = 0; i < reps && !frame_over; i++)
                    place_byte(b);
                if (held_valid) begin
                    held.last = 1'b1;
                    due_q.push_back(held);
                    held_valid = 0;
                end
            end
        end
    endtask

    task automatic apply_config(input logic [2:0] idx, input logic [16:0] val);
        bit hit;
        hit = 1;
        case (idx)
            prpd_pkg::CFG_RLE_ENABLE:     rle_on        = val[0];
            prpd_pkg::CFG_BITS_PER_PLANE: plane_bits    = val[3:0];
            prpd_pkg::CFG_PLANE_COUNT:    plane_cfg     = val[2:0];
            prpd_pkg::CFG_ROW_BYTES:      row_bytes_cfg = val[10:0];
            prpd_pkg::CFG_IMAGE_WIDTH:    width_cfg     = val;
            prpd_pkg::CFG_IMAGE_HEIGHT:   height_cfg    = val;
            default:                      hit           = 0;
        endcase
        // any listed register restarts the frame; the line store keeps its bytes
        if (hit)
            rearm_decoder();
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rle_on        = prpd_pkg::RST_RLE_ENABLE;
            plane_bits    = prpd_pkg::RST_BITS_PER_PLANE;
            plane_cfg     = prpd_pkg::RST_PLANE_COUNT;
            row_bytes_cfg = prpd_pkg::RST_ROW_BYTES;
            width_cfg     = prpd_pkg::RST_IMAGE_WIDTH;
            height_cfg    = prpd_pkg::RST_IMAGE_HEIGHT;
            rearm_decoder();
            due_q.delete();
            held_valid = 0;
            fails      = 0;
        end
        else begin
            // compare first, so a beat taken on this edge cannot cover a stray result
            if (out_valid && out_ready) begin
                seen = {pixel_data, pixel_count, row_index, first_column,
                        last_in_run, frame_done, mode_error};
                if (due_q.size() == 0)
                    report_mismatch({"unexpected group: ", show_group(seen)});
                else begin
                    want = due_q.pop_front();
                    if (seen !== want)
                        report_mismatch({"group mismatch: got ", show_group(seen),
                                         " / want ", show_group(want)});
                end
            end
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (in_valid && in_ready)
                decode_body_beat(body_byte);
        end
        mismatches <= fails;
        groups_due <= due_q.size();
        image_done <= frame_over;
    end

endmodule

[tb/tb_pcx_rle_planar_pixel_decoder_core.sv]
`timescale 1ns / 1ps
// Testbench top for the PCX run-length planar pixel decoder core: clock, reset, register
// writes, body byte stimulus with idling on both sides, and the verdict.
// Depends on prpd_pkg, pcx_decode_checker and pcx_rle_planar_pixel_decoder_core.
module tb_pcx_rle_planar_pixel_decoder_core;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam logic [2:0] CFG_SPARE_LO  = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI  = 3'd7;
    // a run of 63 can keep the decoder busy with no result to show for it
    localparam int         SETTLE_CYCLES = 200;
    localparam int         RANDOM_BEATS  = 240;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  body_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] pixel_data;
    logic [3:0]  pixel_count;
    logic [15:0] row_index;
    logic [15:0] first_column;
    logic        last_in_run;
    logic        frame_done;
    logic        mode_error;

    int          mismatches;
    int          groups_due;
    logic        image_done;

    idle_mode_t  idle_mode;
    logic        rle_now;
    int          live_beats;

    pcx_rle_planar_pixel_decoder_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .body_byte    (body_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_data   (pixel_data),
        .pixel_count  (pixel_count),
        .row_index    (row_index),
        .first_column (first_column),
        .last_in_run  (last_in_run),
        .frame_done   (frame_done),
        .mode_error   (mode_error)
    );

    pcx_decode_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .body_byte    (body_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_data   (pixel_data),
        .pixel_count  (pixel_count),
        .row_index    (row_index),
        .first_column (first_column),
        .last_in_run  (last_in_run),
        .frame_done   (frame_done),
        .mode_error   (mode_error),
        .mismatches   (mismatches),
        .groups_due   (groups_due),
        .image_done   (image_done)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        case (idle_mode)
            IDLE_RECEIVER: out_ready <= ($urandom_range(99) >= 75);
            IDLE_BOTH:     out_ready <= ($urandom_range(99) >= 24);
            default:       out_ready <= 1'b1;
        endcase
    end

    function automatic bit sender_holds();
        case (idle_mode)
            IDLE_SENDER: sender_holds = ($urandom_range(99) < 75);
            IDLE_BOTH:   sender_holds = ($urandom_range(99) < 24);
            default:     sender_holds = 1'b0;
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays up between back-to-back beats.
    task automatic send_beat(input logic [7:0] b);
        if (!image_done)
            live_beats++;
        while (sender_holds()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        body_byte <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic rle, input logic [3:0] bpp,
                                input logic [2:0] planes, input logic [10:0] row_bytes,
                                input logic [16:0] width, input logic [16:0] height);
        // junk above a narrow register's width must be ignored
        write_reg(prpd_pkg::CFG_RLE_ENABLE, {16'($urandom), rle});
        write_reg(prpd_pkg::CFG_BITS_PER_PLANE, {13'($urandom), bpp});
        write_reg(prpd_pkg::CFG_PLANE_COUNT, {14'($urandom), planes});
        write_reg(prpd_pkg::CFG_ROW_BYTES, {6'($urandom), row_bytes});
        write_reg(prpd_pkg::CFG_IMAGE_WIDTH, width);
        write_reg(prpd_pkg::CFG_IMAGE_HEIGHT, height);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 17'($urandom));
        cfg_valid <= 1'b0;
        rle_now = rle;
    endtask

    // Mostly well-formed runs and literals, with some raw noise that may break a run.
    task automatic send_random_beats(input int target);
        int start;
        int pick;
        int r;
        int cnt;
        start = live_beats;
        while (live_beats - start < target && !image_done) begin
            pick = $urandom_range(99);
            if (rle_now && pick < 55) begin
                r   = $urandom_range(99);
                cnt = (r < 70) ? $urandom_range(6) :
                      (r < 90) ? $urandom_range(20, 7) :
                      (r < 95) ? 63 : $urandom_range(63);
                send_beat(prpd_pkg::RUN_MARK | 8'(cnt));
                send_beat(8'($urandom_range(255)));
            end
            else if (pick < 92)
                send_beat(rle_now ? 8'($urandom_range(8'hBF)) : 8'($urandom_range(255)));
            else
                send_beat(8'($urandom));
        end
        // a couple of beats past the final row, which must be dropped
        if (image_done)
            repeat (2) send_beat(8'($urandom));
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (groups_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int          ph;
        int          pick;
        int          rb;
        int          base;
        logic        rle;
        logic [3:0]  bpp;
        logic [2:0]  planes;
        logic [16:0] width;
        logic [16:0] height;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = prpd_pkg::CFG_RLE_ENABLE;
        cfg_data   = 17'h0;
        in_valid   = 1'b0;
        body_byte  = 8'h00;
        out_ready  = 1'b0;
        idle_mode  = IDLE_NONE;
        rle_now    = prpd_pkg::RST_RLE_ENABLE;
        live_beats = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, 1-bit single plane: literals, runs, an empty run,
        // a run of a marker-valued byte and the longest run
        send_beat(8'h00);
        send_beat(8'h3F);
        send_beat(prpd_pkg::RUN_MARK | 8'd3);
        send_beat(8'hFF);
        send_beat(prpd_pkg::RUN_MARK);
        send_beat(8'h55);
        send_beat(prpd_pkg::RUN_MARK | 8'd1);
        send_beat(8'hC2);
        send_beat(prpd_pkg::RUN_MARK | 8'd63);
        send_beat(8'hAA);
        send_beat(8'h80);
        send_beat(8'h7F);
        drain_and_settle();

        // raw 2-bit, width ending on a byte boundary, padding byte closing the frame, then a drop
        program_regs(1'b0, 4'd2, 3'd1, 11'd2, 17'd4, 17'd2);
        send_beat(8'hC5);
        send_beat(8'hFF);
        send_beat(8'h1B);
        send_beat(8'hE4);
        send_beat(8'h12);
        drain_and_settle();

        // RGB with a run crossing plane boundaries into the final pixel
        program_regs(1'b1, 4'd8, 3'd3, 11'd1, 17'd1, 17'd1);
        send_beat(8'h12);
        send_beat(prpd_pkg::RUN_MARK | 8'd2);
        send_beat(8'h34);
        send_beat(8'h56);
        drain_and_settle();

        base = live_beats;
        ph   = 0;
        while (live_beats - base < RANDOM_BEATS) begin
            idle_mode <= idle_mode_t'(ph % 4);
            pick = $urandom_range(7);
            case (pick)
                0: begin bpp = 4'd1; planes = 3'd1; end
                1: begin bpp = 4'd1; planes = 3'd3; end
                2: begin bpp = 4'd1; planes = 3'd4; end
                3: begin bpp = 4'd2; planes = 3'd1; end
                4: begin bpp = 4'd8; planes = 3'd1; end
                5: begin bpp = 4'd8; planes = 3'd3; end
                default:
                begin
                    bpp    = 4'($urandom_range(15));
                    planes = 3'($urandom_range(7));
                end
            endcase
            pick = $urandom_range(9);
            rb   = (pick < 7) ? $urandom_range(6, 1) :
                   (pick == 7) ? 0 :
                   (pick == 8) ? $urandom_range(2047) : prpd_pkg::MAX_ROW_BYTES;
            pick  = $urandom_range(9);
            width = (pick < 8) ? 17'($urandom_range(rb * 8 + 4)) :
                    (pick == 8) ? 17'h10000 : 17'h1FFFF;
            pick   = $urandom_range(9);
            height = (pick < 6) ? 17'($urandom_range(4, 1)) :
                     (pick == 6) ? 17'd0 :
                     (pick == 7) ? 17'h10000 :
                     (pick == 8) ? 17'h1FFFF : 17'($urandom_range(17'h1FFFF));
            rle = ($urandom_range(3) != 0);

            // pin the extremes on the first few settings
            case (ph)
                0:
                begin
                    rle = 1'b1; bpp = 4'd0; planes = 3'd0; rb = 0;
                    width = 17'd0; height = 17'd0;
                end
                1:
                begin
                    rle = 1'b0; bpp = 4'd15; planes = 3'd7; rb = 2047;
                    width = 17'h1FFFF; height = 17'h1FFFF;
                end
                2:
                begin
                    rle = 1'b1; bpp = 4'd1; planes = 3'd4; rb = prpd_pkg::MAX_ROW_BYTES;
                    width = 17'h10000; height = 17'h10000;
                end
                3:
                begin
                    rle = 1'b0; bpp = 4'd8; planes = 3'd3; rb = 3;
                    width = 17'd2; height = 17'd2;
                end
                default: ;
            endcase

            program_regs(rle, bpp, planes, 11'(rb), width, height);
            send_random_beats(24);
            drain_and_settle();
            ph++;
        end

        if (mismatches == 0 && groups_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
